@@ design/mam_pkg.sv @@
// mam_pkg: shared types and constants for the modular add/multiply block
// depends on nothing; used by modular_add_multiply and its testbench

package mam_pkg;

	localparam int unsigned FIELD_W      = 64;
	localparam int unsigned WORD_W_DFLT  = 64;

	typedef enum logic {
		ACT_ADD = 1'b0,
		ACT_MUL = 1'b1
	} mam_action_t;

	typedef struct packed {
		mam_action_t         action;
		logic [FIELD_W-1:0]  operand_a;
		logic [FIELD_W-1:0]  operand_b;
	} mam_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0]  residue;
		logic                zero_modulus_error;
	} mam_result_t;

endpackage

@@ design/mam_addmod.sv @@
// mam_addmod: shared step unit, (x + y + cin) mod m for x, y below m
// one add followed by one compare-subtract; no package dependency

module mam_addmod #(
	parameter int unsigned WORD_WIDTH = 64
) (
	input  logic [WORD_WIDTH-1:0] x,
	input  logic [WORD_WIDTH-1:0] y,
	input  logic                  cin,
	input  logic [WORD_WIDTH-1:0] m,
	output logic [WORD_WIDTH-1:0] sum
);

	logic [WORD_WIDTH:0]   raw;
	logic [WORD_WIDTH+1:0] diff;

	always_comb begin
		raw  = {1'b0, x} + {1'b0, y} + {{WORD_WIDTH{1'b0}}, cin};
		diff = {1'b0, raw} - {2'b00, m};
		if (diff[WORD_WIDTH+1]) begin
			sum = raw[WORD_WIDTH-1:0];
		end else begin
			sum = diff[WORD_WIDTH-1:0];
		end
	end

endmodule

@@ design/modular_add_multiply.sv @@
// modular_add_multiply: top level, sequencer around the shared mod-add unit
// depends on mam_pkg and mam_addmod
//
// usage
//  cfg channel: one transfer writes the modulus (low WORD_WIDTH bits kept);
//  write it only while the block is idle. reset sets the modulus to 1
//  item channel: one transfer carries action, operand_a, operand_b; the
//  block is busy, and not ready, until its result is loaded for output
//  result channel: one transfer per item with the residue and the error flag
//  steps from item transfer to result valid:
//   add       reduce a, reduce b, one add, output load
//   multiply  reduce a, double per bit of b with an extra add per set
//             bit, output load
//   zero modulus: output load only, residue 0 with the error flag
//  every step but the output load is a pass through the shared (x + y + cin)
//  mod m unit; the next item is taken only after the last result is loaded
//  the result register holds a finished result while the receiver stalls;
//  the next item is accepted meanwhile and waits for that slot when done
//  asynchronous reset clears the sequencer and empties the result register

module modular_add_multiply #(
	parameter int unsigned WORD_WIDTH = mam_pkg::WORD_W_DFLT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mam_pkg::FIELD_W-1:0] cfg_data,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  mam_pkg::mam_item_t         item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output mam_pkg::mam_result_t       result
);

	import mam_pkg::*;

	localparam int unsigned CW = $clog2(WORD_WIDTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED_A,
		S_RED_B,
		S_ADD,
		S_MUL_DBL,
		S_MUL_ADD,
		S_FINISH
	} state_t;

	state_t                state_q;
	logic [WORD_WIDTH-1:0] m_q;
	logic [WORD_WIDTH-1:0] acc_q;
	logic [WORD_WIDTH-1:0] x_q;
	logic [WORD_WIDTH-1:0] sh_q;
	logic [WORD_WIDTH-1:0] b_q;
	logic [CW-1:0]         cnt_q;
	mam_action_t           act_q;
	logic                  err_q;
	logic                  out_valid_q;
	mam_result_t           out_q;

	logic [WORD_WIDTH-1:0] ux;
	logic [WORD_WIDTH-1:0] uy;
	logic                  ucin;
	logic [WORD_WIDTH-1:0] usum;

	assign cfg_ready    = 1'b1;
	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		ux   = acc_q;
		uy   = acc_q;
		ucin = 1'b0;
		unique case (state_q)
			S_RED_A, S_RED_B: begin
				ucin = sh_q[WORD_WIDTH-1];
			end
			S_ADD, S_MUL_ADD: begin
				uy = x_q;
			end
			default: begin
				ucin = 1'b0;
			end
		endcase
	end

	mam_addmod #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_addmod (
		.x   (ux),
		.y   (uy),
		.cin (ucin),
		.m   (m_q),
		.sum (usum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			m_q         <= {{(WORD_WIDTH-1){1'b0}}, 1'b1};
			out_valid_q <= 1'b0;
			err_q       <= 1'b0;
			cnt_q       <= '0;
			act_q       <= ACT_ADD;
			acc_q       <= '0;
			x_q         <= '0;
			sh_q        <= '0;
			b_q         <= '0;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				m_q <= cfg_data[WORD_WIDTH-1:0];
			end
			if (state_q == S_FINISH && (!out_valid_q || result_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						act_q <= item.action;
						sh_q  <= item.operand_a[WORD_WIDTH-1:0];
						b_q   <= item.operand_b[WORD_WIDTH-1:0];
						acc_q <= '0;
						cnt_q <= CW'(WORD_WIDTH - 1);
						if (m_q == '0) begin
							err_q   <= 1'b1;
							state_q <= S_FINISH;
						end else begin
							err_q   <= 1'b0;
							state_q <= S_RED_A;
						end
					end
				end
				S_RED_A: begin
					if (cnt_q == '0) begin
						x_q   <= usum;
						acc_q <= '0;
						sh_q  <= b_q;
						cnt_q <= CW'(WORD_WIDTH - 1);
						state_q <= (act_q == ACT_MUL) ? S_MUL_DBL : S_RED_B;
					end else begin
						acc_q <= usum;
						sh_q  <= sh_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_RED_B: begin
					acc_q <= usum;
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					acc_q   <= usum;
					state_q <= S_FINISH;
				end
				S_MUL_DBL: begin
					acc_q <= usum;
					if (sh_q[WORD_WIDTH-1]) begin
						state_q <= S_MUL_ADD;
					end else begin
						sh_q  <= sh_q << 1;
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == '0) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_MUL_ADD: begin
					acc_q <= usum;
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q - 1'b1;
					state_q <= (cnt_q == '0) ? S_FINISH : S_MUL_DBL;
				end
				S_FINISH: begin
					if (!out_valid_q || result_ready) begin
						out_q.residue            <= FIELD_W'(acc_q);
						out_q.zero_modulus_error <= err_q;
						state_q                  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// error result always carries a zero residue
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.zero_modulus_error |-> result.residue == '0)
		else $error("error result with nonzero residue");

	// a clean result lies below the modulus
	a_res_below_m: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.zero_modulus_error |-> result.residue < FIELD_W'(m_q))
		else $error("residue not below modulus");

	// running residue stays reduced while working
	a_acc_below_m: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE && !err_q |-> acc_q < m_q)
		else $error("running residue not reduced");

	// an item transfer makes the block busy
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("ready after item transfer");

endmodule

@@ tb/sv/tb_modular_add_multiply.sv @@
// tb_modular_add_multiply: self-checking testbench for the modular add/multiply block
// depends on mam_pkg and modular_add_multiply; a scoreboard class predicts each residue
// and checks them in order; tasks drive items and modulus, a loop drives result_ready

module tb_modular_add_multiply;
	import mam_pkg::*;

	localparam int unsigned WORD_WIDTH  = WORD_W_DFLT;
	localparam logic [63:0] WORD_MASK   = (WORD_WIDTH >= 64) ? {64{1'b1}} :
		((64'd1 << (WORD_WIDTH % 64)) - 64'd1);
	localparam int          CYCLE_LIMIT = 2500000;
	localparam int          HOLD_CYCLES = 900;
	localparam int          RAND_PHASES = 24;
	localparam int          PHASE_ITEMS = 75;
	localparam logic [63:0] ALL_ONES    = {64{1'b1}};

	class residue_scoreboard;
		logic [63:0] modulus;
		mam_result_t expected_results[$];
		int          errors;

		function new();
			modulus = 64'd1;
			errors  = 0;
		endfunction

		function mam_result_t modular_residue(mam_item_t it);
			logic [63:0]  m;
			logic [63:0]  a;
			logic [63:0]  b;
			logic [127:0] prod;
			logic [64:0]  sum;
			mam_result_t  r;
			m = modulus & WORD_MASK;
			a = it.operand_a & WORD_MASK;
			b = it.operand_b & WORD_MASK;
			r.residue = '0;
			r.zero_modulus_error = 1'b0;
			if (m == 64'd0) begin
				r.zero_modulus_error = 1'b1;
			end else if (it.action == ACT_MUL) begin
				prod = {64'd0, a} * {64'd0, b};
				prod = prod % {64'd0, m};
				r.residue = prod[63:0];
			end else begin
				sum = {1'b0, a % m} + {1'b0, b % m};
				if (sum >= {1'b0, m})
					sum = sum - {1'b0, m};
				r.residue = sum[63:0];
			end
			return r;
		endfunction

		function void note_item(mam_item_t it);
			expected_results.push_back(modular_residue(it));
		endfunction

		function void check_result(mam_result_t got);
			mam_result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: residue %h error %b",
						got.residue, got.zero_modulus_error);
				return;
			end
			want = expected_results.pop_front();
			if (got.residue !== want.residue ||
					got.zero_modulus_error !== want.zero_modulus_error) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected residue %h error %b, got residue %h error %b",
						want.residue, want.zero_modulus_error,
						got.residue, got.zero_modulus_error);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] cfg_data;
	logic        item_valid;
	logic        item_ready;
	mam_item_t   item;
	logic        result_valid;
	logic        result_ready;
	mam_result_t result;

	residue_scoreboard sb;
	bit                no_idle;
	bit                hold_rx;
	int                cycle_count;

	modular_add_multiply #(
		.WORD_WIDTH(WORD_WIDTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("modular_add_multiply verification failed");
		$finish;
	end

	function automatic mam_item_t make_item(mam_action_t act, logic [63:0] a, logic [63:0] b);
		mam_item_t it;
		it.action    = act;
		it.operand_a = a;
		it.operand_b = b;
		return it;
	endfunction

	function automatic logic [63:0] pick_operand(logic [63:0] m);
		logic [63:0] v;
		case ($urandom_range(0, 5))
			1: v = 64'($urandom_range(0, 15));
			2: v = m - 64'($urandom_range(0, 3));
			3: v = ALL_ONES - 64'($urandom_range(0, 3));
			4: v = 64'd1 << $urandom_range(0, 63);
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	function automatic logic [63:0] pick_modulus(int p);
		logic [63:0] m;
		case (p % 8)
			0: m = {$urandom, $urandom};
			1: m = 64'($urandom_range(2, 1000));
			2: m = {1'b1, 31'($urandom), $urandom};
			3: m = ALL_ONES;
			4: m = 64'd1 << $urandom_range(1, 63);
			5: m = 64'd0;
			6: m = 64'd1;
			default: m = ALL_ONES - 64'($urandom_range(1, 1000));
		endcase
		return m;
	endfunction

	task automatic send_item(input mam_item_t it);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		sb.note_item(it);
	endtask

	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_modulus(input logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.modulus = value & WORD_MASK;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls, plus a long hold-off when asked
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_rx) begin
				@(negedge clk);
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rx = 1'b0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 17);
			if (stall != 0) begin
				@(negedge clk);
				result_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			sb.check_result(result);
		end
	end

	initial begin
		logic [63:0] m;
		logic [63:0] half_up;
		sb           = new();
		no_idle      = 1'b0;
		hold_rx      = 1'b0;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		item_valid   = 1'b0;
		item         = '0;
		result_ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// reset modulus of one
		send_item(make_item(ACT_ADD, ALL_ONES, ALL_ONES));
		send_item(make_item(ACT_MUL, ALL_ONES, ALL_ONES));
		send_item(make_item(ACT_ADD, 64'd0, 64'd0));
		drain_results();

		// zero modulus flags an error
		write_modulus(64'd0);
		send_item(make_item(ACT_ADD, ALL_ONES, 64'd1));
		send_item(make_item(ACT_MUL, ALL_ONES, ALL_ONES));
		drain_results();

		write_modulus(ALL_ONES);
		send_item(make_item(ACT_ADD, ALL_ONES, ALL_ONES));
		send_item(make_item(ACT_MUL, ALL_ONES, ALL_ONES));
		send_item(make_item(ACT_ADD, ALL_ONES - 1, ALL_ONES - 1));
		send_item(make_item(ACT_MUL, ALL_ONES - 1, ALL_ONES - 1));
		send_item(make_item(ACT_MUL, 64'd0, ALL_ONES));
		send_item(make_item(ACT_ADD, ALL_ONES - 1, 64'd1));
		drain_results();

		// modulus above half the word: sums overflow the word
		half_up = {1'b1, 63'd3};
		write_modulus(half_up);
		send_item(make_item(ACT_ADD, half_up - 1, half_up - 1));
		send_item(make_item(ACT_MUL, half_up - 1, half_up - 1));
		send_item(make_item(ACT_ADD, ALL_ONES, ALL_ONES));
		send_item(make_item(ACT_MUL, ALL_ONES, half_up - 1));
		send_item(make_item(ACT_ADD, half_up - 1, 64'd1));
		drain_results();

		write_modulus(64'd2);
		send_item(make_item(ACT_MUL, ALL_ONES, {1'b1, 63'd0}));
		send_item(make_item(ACT_ADD, 64'd1, 64'd1));
		drain_results();

		for (int p = 0; p < RAND_PHASES; p++) begin
			m = pick_modulus(p);
			write_modulus(m);
			no_idle = (p % 5 == 4);
			if (p == 2 || p == 13)
				hold_rx = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(make_item(mam_action_t'($urandom_range(0, 1)),
					pick_operand(m), pick_operand(m)));
			drain_results();
		end

		repeat (3 * WORD_WIDTH + 8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("modular_add_multiply verification clean");
		else
			$display("modular_add_multiply verification failed");
		$finish;
	end

endmodule
